// File: hdl/rrd_pkg.sv
// ---------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants of the raster run-length byte decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;
  localparam int OFFS_W = 24;

  // escape byte that opens a run token
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h80;

  // reset value of the image size register
  localparam logic [OFFS_W-1:0] IMAGE_SIZE_RST = 24'd1;

  // token parser phase
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_COUNT = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  // one decoded run, as it travels from parser to output queue
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  length;
    logic [OFFS_W-1:0] offset;
    logic              complete;
  } run_t;

endpackage

`default_nettype wire

// File: hdl/rrd_in_if.sv
// ---------------------------------------------------------------------------
// rrd_in_if
// Encoded byte channel: one stream byte and a begin flag per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrd_in_if;
  logic                      valid;
  logic                      ready;
  logic [rrd_pkg::BYTE_W-1:0] in_byte;
  logic                      begin_req;

  modport source (output valid, output in_byte, output begin_req, input ready);
  modport sink   (input valid, input in_byte, input begin_req, output ready);
endinterface

`default_nettype wire

// File: hdl/rrd_out_if.sv
// ---------------------------------------------------------------------------
// rrd_out_if
// Decoded run channel: one run per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrd_out_if;
  logic                       valid;
  logic                       ready;
  logic [rrd_pkg::BYTE_W-1:0] run_value;
  logic [rrd_pkg::LEN_W-1:0]  run_length;
  logic [rrd_pkg::OFFS_W-1:0] run_offset;
  logic                       image_complete;

  modport source (output valid, output run_value, output run_length,
                  output run_offset, output image_complete, input ready);
  modport sink   (input valid, input run_value, input run_length,
                  input run_offset, input image_complete, output ready);
endinterface

`default_nettype wire

// File: hdl/rrd_cfg_if.sv
// ---------------------------------------------------------------------------
// rrd_cfg_if
// Configuration write channel carrying the image size.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rrd_pkg::OFFS_W-1:0] image_size;

  modport source (output valid, output image_size, input ready);
  modport sink   (input valid, input image_size, output ready);
endinterface

`default_nettype wire

// File: hdl/raster_rle_byte_decoder.sv
// ---------------------------------------------------------------------------
// raster_rle_byte_decoder
// Run-length raster byte decoder: literal bytes and escape-coded runs in,
// clipped runs with their image offsets out.
// ---------------------------------------------------------------------------
//
//   port     dir   payload                                        per transaction
//   in_ch    in    in_byte, begin_req                             one encoded byte
//   out_ch   out   run_value, run_length, run_offset,             one decoded run
//                  image_complete
//   cfg_ch   in    image_size                                     size register write
//
// One byte is taken every cycle while the queue has room; a byte that finishes
// a token registers its run in a two-entry queue, whose head drives out_ch.
// The parser's offset add and room compare set the cycle; input stalls only
// when the queue holds two runs the output has not taken.
// Synchronous reset (rst_n low) empties the queue, clears token state and
// offset and sets the image size to 1. cfg_ch is always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module raster_rle_byte_decoder (
  input wire logic clk,
  input wire logic rst_n,
  rrd_in_if.sink    in_ch,
  rrd_out_if.source out_ch,
  rrd_cfg_if.sink   cfg_ch
);

  logic          space_ok;
  logic          push;
  rrd_pkg::run_t push_run;

  // token parser and offset tracker
  rrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .space_ok (space_ok),
    .push     (push),
    .push_run (push_run)
  );

  // run queue feeding the output channel
  rrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: hdl/rrd_front.sv
// ---------------------------------------------------------------------------
// rrd_front
// Token parser: classifies each byte, tracks the write offset, clips runs
// to the image and hands finished runs to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rrd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rrd_in_if.sink             in_ch,
  rrd_cfg_if.sink            cfg_ch,
  input  wire logic          space_ok,
  output      logic          push,
  output      rrd_pkg::run_t push_run
);

  rrd_pkg::phase_t               phase_r, phase_nxt;
  logic [rrd_pkg::BYTE_W-1:0]    count_r, count_nxt;
  logic [rrd_pkg::OFFS_W-1:0]    offset_r, offset_nxt;
  logic [rrd_pkg::OFFS_W-1:0]    size_r;

  logic                          accept;
  rrd_pkg::phase_t               ph_cur;
  logic [rrd_pkg::BYTE_W-1:0]    cnt_cur;
  logic [rrd_pkg::OFFS_W-1:0]    off_cur;
  logic                          full;
  logic                          emit;
  logic [rrd_pkg::BYTE_W-1:0]    emit_value;
  logic [rrd_pkg::LEN_W-1:0]     emit_len;
  logic [rrd_pkg::OFFS_W-1:0]    room;
  logic                          clip;
  logic [rrd_pkg::LEN_W-1:0]     len_clipped;
  logic [rrd_pkg::OFFS_W-1:0]    off_after;

  assign in_ch.ready  = space_ok;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && space_ok;

  // begin request clears token state and offset ahead of the byte
  assign ph_cur  = in_ch.begin_req ? rrd_pkg::PH_FLAG : phase_r;
  assign cnt_cur = in_ch.begin_req ? '0 : count_r;
  assign off_cur = in_ch.begin_req ? '0 : offset_r;
  assign full    = off_cur >= size_r;

  // token classification
  always_comb begin
    phase_nxt  = ph_cur;
    count_nxt  = cnt_cur;
    emit       = 1'b0;
    emit_value = in_ch.in_byte;
    emit_len   = rrd_pkg::LEN_W'(1);
    if (!full) begin
      case (ph_cur)
        rrd_pkg::PH_COUNT: begin
          if (in_ch.in_byte == '0) begin
            phase_nxt  = rrd_pkg::PH_FLAG;
            emit       = 1'b1;
            emit_value = rrd_pkg::ESCAPE_BYTE;
          end else begin
            count_nxt = in_ch.in_byte;
            phase_nxt = rrd_pkg::PH_VALUE;
          end
        end
        rrd_pkg::PH_VALUE: begin
          phase_nxt = rrd_pkg::PH_FLAG;
          emit      = 1'b1;
          emit_len  = {1'b0, cnt_cur} + rrd_pkg::LEN_W'(1);
        end
        default: begin
          if (in_ch.in_byte == rrd_pkg::ESCAPE_BYTE) begin
            phase_nxt = rrd_pkg::PH_COUNT;
          end else begin
            phase_nxt = rrd_pkg::PH_FLAG;
            emit      = 1'b1;
          end
        end
      endcase
    end
  end

  // clip the run to the space left in the image
  assign room        = size_r - off_cur;
  assign clip        = {{(rrd_pkg::OFFS_W-rrd_pkg::LEN_W){1'b0}}, emit_len} > room;
  assign len_clipped = clip ? room[rrd_pkg::LEN_W-1:0] : emit_len;
  assign off_after   = clip ? size_r
                            : off_cur + {{(rrd_pkg::OFFS_W-rrd_pkg::LEN_W){1'b0}}, emit_len};
  assign offset_nxt  = emit ? off_after : off_cur;

  assign push              = accept && emit;
  assign push_run.value    = emit_value;
  assign push_run.length   = len_clipped;
  assign push_run.offset   = off_cur;
  assign push_run.complete = off_after >= size_r;

  // token state and offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rrd_pkg::PH_FLAG;
      count_r  <= '0;
      offset_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      offset_r <= offset_nxt;
    end
  end

  // image size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= rrd_pkg::IMAGE_SIZE_RST;
    end else if (cfg_ch.valid) begin
      size_r <= cfg_ch.image_size;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rrd_queue.sv
// ---------------------------------------------------------------------------
// rrd_queue
// Two-entry run queue between parser and output channel; its head drives
// the output transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module rrd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rrd_pkg::run_t push_run,
  output      logic          space_ok,
  rrd_out_if.source          out_ch
);

  rrd_pkg::run_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          pop;
  rrd_pkg::run_t head;

  assign space_ok = fill_r != 2'd2;
  assign pop      = out_ch.valid && out_ch.ready;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_run;
    end
  end

  // head entry onto the output channel
  assign head                  = entry_r[rd_ptr_r];
  assign out_ch.valid          = fill_r != 2'd0;
  assign out_ch.run_value      = head.value;
  assign out_ch.run_length     = head.length;
  assign out_ch.run_offset     = head.offset;
  assign out_ch.image_complete = head.complete;

endmodule

`default_nettype wire
